FILE: rtl/tfd_pkg.sv
// Shared types and constants for the telemetry frame deframer.
`default_nettype none
package tfd_pkg;

  localparam logic [7:0] HEAD_BYTE  = 8'hAA;
  localparam logic [7:0] FIXED_ADDR = 8'h05;

  // Largest payload the payload RAM can hold, whatever the buffer size.
  localparam int STORE_DEPTH = 58;

  // Configuration register indexes
  localparam logic [7:0] REG_OWN_ADDRESS       = 8'd0;
  localparam logic [7:0] REG_BROADCAST_ADDRESS = 8'd1;

  localparam logic [7:0] OWN_ADDRESS_RST       = 8'd5;
  localparam logic [7:0] BROADCAST_ADDRESS_RST = 8'd255;

  localparam logic STATUS_PAYLOAD  = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic start_sum;     // head accepted: sums restart from this word
    logic accumulate;    // add word into both running sums
    logic load_dest;
    logic load_func;
    logic load_len;      // also clears the write pointer
    logic store_payload;
    logic load_chk1;
    logic emit_error;
    logic start_replay;  // clears the read pointer
    logic rd_issue;
    logic emit_payload;  // load output register, advance read pointer
  } tfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic head_match;
    logic addr_match;
    logic len_ok;
    logic payload_done;
    logic check_ok;
    logic replay_last;
    logic out_free;
  } tfd_stat_t;

endpackage
`default_nettype wire

FILE: rtl/telemetry_frame_deframer_core.sv
// An error word is registered in the cycle after the second check byte is accepted; the
// first payload word passes through the RD and LOAD states and then the output register.
// Throughput: one received word per cycle while parsing, the second check byte waiting on
// a free output; good frames replay via RAM read then output load, input held meanwhile.
// Reset (rst, synchronous): hunt for head, output empty, addresses back to 5 and 255.
// The payload RAM is not cleared; only bytes written in the current frame are read.
`default_nettype none
module telemetry_frame_deframer_core
  import tfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            status,
  output logic [7:0]      dest_address,
  output logic [7:0]      function_id,
  output logic [5:0]      payload_length,
  output logic [5:0]      byte_index,
  output logic [7:0]      payload_byte,
  output logic [7:0]      sum_check,
  output logic [7:0]      add_check,
  output logic            last
);

  localparam int MaxLen = ((BUFFER_BYTES - 6) < STORE_DEPTH) ? (BUFFER_BYTES - 6)
                                                             : STORE_DEPTH;

  tfd_cmd_t  cmd;
  tfd_stat_t stat;

  assign cfg_ready = 1'b1;

  tfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tfd_datapath #(
    .MAX_LEN (MaxLen)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .dest_address   (dest_address),
    .function_id    (function_id),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .sum_check      (sum_check),
    .add_check      (add_check),
    .last           (last)
  );

endmodule
`default_nettype wire

FILE: rtl/tfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 58,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tfd_ctrl.sv
// Frame parse and replay state machine.
`default_nettype none
module tfd_ctrl
  import tfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tfd_stat_t stat,
  output tfd_cmd_t       cmd
);

  typedef enum logic [3:0] {
    HUNT, DEST, FUNC, LEN, PAYLOAD, CHK1, CHK2, RD, LOAD
  } state_t;

  state_t state, state_next;
  logic   accept;

  always_comb begin
    unique case (state)
      HUNT, DEST, FUNC, LEN, PAYLOAD, CHK1: in_ready = 1'b1;
      CHK2:                                 in_ready = stat.out_free;
      default:                              in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      HUNT: if (accept && stat.head_match) begin
        cmd.start_sum = 1'b1;
        state_next    = DEST;
      end
      DEST: if (accept) begin
        if (stat.addr_match) begin
          cmd.load_dest  = 1'b1;
          cmd.accumulate = 1'b1;
          state_next     = FUNC;
        end else begin
          state_next = HUNT;
        end
      end
      FUNC: if (accept) begin
        cmd.load_func  = 1'b1;
        cmd.accumulate = 1'b1;
        state_next     = LEN;
      end
      LEN: if (accept) begin
        if (stat.len_ok) begin
          cmd.load_len   = 1'b1;
          cmd.accumulate = 1'b1;
          state_next     = PAYLOAD;
        end else begin
          state_next = HUNT;
        end
      end
      PAYLOAD: if (accept) begin
        cmd.store_payload = 1'b1;
        cmd.accumulate    = 1'b1;
        if (stat.payload_done) begin
          state_next = CHK1;
        end
      end
      CHK1: if (accept) begin
        cmd.load_chk1 = 1'b1;
        state_next    = CHK2;
      end
      CHK2: if (accept) begin
        if (stat.check_ok) begin
          cmd.start_replay = 1'b1;
          state_next       = RD;
        end else begin
          cmd.emit_error = 1'b1;
          state_next     = HUNT;
        end
      end
      RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = LOAD;
      end
      LOAD: if (stat.out_free) begin
        cmd.emit_payload = 1'b1;
        state_next       = stat.replay_last ? HUNT : RD;
      end
      default: state_next = HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tfd_datapath.sv
// Frame registers, running sums, payload RAM and output register.
`default_nettype none
module tfd_datapath
  import tfd_pkg::*;
#(
  parameter int MAX_LEN = 58
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic [7:0] rx_byte,
  input  wire tfd_cmd_t   cmd,
  output tfd_stat_t       stat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            status,
  output logic [7:0]      dest_address,
  output logic [7:0]      function_id,
  output logic [5:0]      payload_length,
  output logic [5:0]      byte_index,
  output logic [7:0]      payload_byte,
  output logic [7:0]      sum_check,
  output logic [7:0]      add_check,
  output logic            last
);

  localparam int         AW          = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [7:0] MaxLenByte  = 8'(MAX_LEN);

  logic [7:0] own_address, broadcast_address;
  logic [7:0] frame_dest, frame_function, first_check_byte;
  logic [5:0] frame_length;
  logic [5:0] wr_idx, rd_idx;
  logic [7:0] running_sum, running_sos;
  logic [7:0] sum_next;
  logic [7:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= OWN_ADDRESS_RST;
      broadcast_address <= BROADCAST_ADDRESS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_OWN_ADDRESS) begin
        own_address <= cfg_data;
      end else if (cfg_index == REG_BROADCAST_ADDRESS) begin
        broadcast_address <= cfg_data;
      end
    end
  end

  assign sum_next = cmd.start_sum ? rx_byte : running_sum + rx_byte;

  always_ff @(posedge clk) begin
    if (cmd.start_sum) begin
      running_sum <= sum_next;
      running_sos <= sum_next;
    end else if (cmd.accumulate) begin
      running_sum <= sum_next;
      running_sos <= running_sos + sum_next;
    end
    if (cmd.load_dest)  frame_dest <= rx_byte;
    if (cmd.load_func)  frame_function <= rx_byte;
    if (cmd.load_len) begin
      frame_length <= rx_byte[5:0];
      wr_idx       <= '0;
    end else if (cmd.store_payload) begin
      wr_idx <= wr_idx + 6'd1;
    end
    if (cmd.load_chk1) first_check_byte <= rx_byte;
    if (cmd.start_replay) begin
      rd_idx <= '0;
    end else if (cmd.emit_payload) begin
      rd_idx <= rd_idx + 6'd1;
    end
  end

  tfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_payload),
    .waddr (wr_idx[AW-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.head_match   = (rx_byte == HEAD_BYTE);
    stat.addr_match   = (rx_byte == own_address) || (rx_byte == broadcast_address)
                        || (rx_byte == FIXED_ADDR);
    stat.len_ok       = (rx_byte != 8'd0) && (rx_byte <= MaxLenByte);
    stat.payload_done = (wr_idx + 6'd1 == frame_length);
    stat.check_ok     = (first_check_byte == running_sum) && (rx_byte == running_sos);
    stat.replay_last  = (rd_idx + 6'd1 == frame_length);
    stat.out_free     = !out_valid || out_ready;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_error || cmd.emit_payload) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_error || cmd.emit_payload) begin
      dest_address   <= frame_dest;
      function_id    <= frame_function;
      payload_length <= frame_length;
      sum_check      <= running_sum;
      add_check      <= running_sos;
    end
    if (cmd.emit_error) begin
      status       <= STATUS_MISMATCH;
      byte_index   <= '0;
      payload_byte <= '0;
      last         <= 1'b1;
    end else if (cmd.emit_payload) begin
      status       <= STATUS_PAYLOAD;
      byte_index   <= rd_idx;
      payload_byte <= ram_rdata;
      last         <= stat.replay_last;
    end
  end

endmodule
`default_nettype wire
